// ===== hdl/hsl_pkg.sv =====
// Shared types, constants and helper functions for the HSL to RGB converter.
// Used by every module of the converter; depends on nothing else.

package hsl_pkg;

    // Field widths of the stream words.
    localparam int HUE_W         = 9;
    localparam int SL_W          = 11;
    localparam int CH_W          = 8;
    localparam int IN_DATA_W     = 32;
    localparam int OUT_DATA_W    = 24;

    // Default number of fraction bits for saturation and lightness.
    localparam int FRAC_BITS_DEF = 10;

    // Segment weight covers 0..60 degrees.
    localparam int W_BITS        = 6;

    // Hue angles in whole degrees.
    localparam logic [HUE_W-1:0] ANG_60  = 9'd60;
    localparam logic [HUE_W-1:0] ANG_120 = 9'd120;
    localparam logic [HUE_W-1:0] ANG_180 = 9'd180;
    localparam logic [HUE_W-1:0] ANG_240 = 9'd240;
    localparam logic [HUE_W-1:0] ANG_360 = 9'd360;

    localparam logic [W_BITS-1:0] W_FULL = 6'd60;
    localparam logic [W_BITS-1:0] W_NONE = 6'd0;
    localparam logic [CH_W-1:0]   CH_MAX = 8'd255;

    // Per-stage load enables of the pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    // Per-word values that travel alongside the temporaries.
    typedef struct packed {
        logic [W_BITS-1:0] w_r;
        logic [W_BITS-1:0] w_g;
        logic [W_BITS-1:0] w_b;
        logic              gray;
        logic [CH_W-1:0]   gray_val;
    } t_side;

    // Signed width that holds both temporaries and their difference.
    function automatic int temp_width(int fb);
        return ((fb > 10) ? fb : 10) + 15;
    endfunction

    // Weight of (T1 - T2) in sixtieths for a channel angle in 0..360.
    function automatic logic [W_BITS-1:0] seg_weight(logic [HUE_W-1:0] ang);
        logic [HUE_W-1:0] down;
        down = ANG_240 - ang;
        if (ang < ANG_60) begin
            return ang[W_BITS-1:0];
        end else if (ang < ANG_180) begin
            return W_FULL;
        end else if (ang < ANG_240) begin
            return down[W_BITS-1:0];
        end else begin
            return W_NONE;
        end
    endfunction

endpackage

// ===== hdl/hsl_prep.sv =====
// First pipeline stage: hue wrap, channel weights, gray value and l*s product.
// Depends on hsl_pkg.

module hsl_prep import hsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  t_pipe_en             i_en,
    input  logic [HUE_W-1:0]     i_hue,
    input  logic [SL_W-1:0]      i_sat,
    input  logic [SL_W-1:0]      i_light,
    output logic [SL_W-1:0]      o_light,
    output logic [SL_W-1:0]      o_sat,
    output logic [2*SL_W-1:0]    o_lxs,
    output logic                 o_low,
    output t_side                o_side
);

    localparam int GP_W = SL_W + CH_W;

    logic [HUE_W-1:0]  hue_w;
    logic [HUE_W-1:0]  ang_r_raw;
    logic [HUE_W-1:0]  ang_r;
    logic [HUE_W-1:0]  ang_b;
    logic [GP_W-1:0]   gray_prod;
    logic [GP_W-1:0]   gray_sh;
    logic [CH_W-1:0]   gray_val;

    logic [SL_W-1:0]   r_light;
    logic [SL_W-1:0]   r_sat;
    logic [2*SL_W-1:0] r_lxs;
    logic              r_low;
    t_side             r_side;

    // Hue modulo 360 and the red and blue offset angles.
    always_comb begin
        hue_w     = (i_hue >= ANG_360) ? (i_hue - ANG_360) : i_hue;
        ang_r_raw = hue_w + ANG_120;
        ang_r     = (ang_r_raw > ANG_360) ? (ang_r_raw - ANG_360) : ang_r_raw;
        ang_b     = (hue_w < ANG_120) ? (hue_w + ANG_240) : (hue_w - ANG_120);
    end

    // Gray level is l*255 scaled down by the fraction bits, saturated.
    always_comb begin
        gray_prod = {i_light, {CH_W{1'b0}}} - GP_W'(i_light);
        gray_sh   = gray_prod >> FRAC_BITS;
        gray_val  = (|gray_sh[GP_W-1:CH_W]) ? CH_MAX : gray_sh[CH_W-1:0];
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_light         <= i_light;
            r_sat           <= i_sat;
            r_lxs           <= (2*SL_W)'(i_light) * (2*SL_W)'(i_sat);
            r_low           <= ((i_light >> (FRAC_BITS - 1)) == '0);
            r_side.w_r      <= seg_weight(ang_r);
            r_side.w_g      <= seg_weight(hue_w);
            r_side.w_b      <= seg_weight(ang_b);
            r_side.gray     <= (i_sat == '0);
            r_side.gray_val <= gray_val;
        end
    end

    assign o_light = r_light;
    assign o_sat   = r_sat;
    assign o_lxs   = r_lxs;
    assign o_low   = r_low;
    assign o_side  = r_side;

endmodule

// ===== hdl/hsl_temps.sv =====
// Second pipeline stage: the temporaries T1 and T2, scaled by F squared.
// Depends on hsl_pkg.

module hsl_temps import hsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  t_pipe_en                                 i_en,
    input  logic [SL_W-1:0]                          i_light,
    input  logic [SL_W-1:0]                          i_sat,
    input  logic [2*SL_W-1:0]                        i_lxs,
    input  logic                                     i_low,
    input  t_side                                    i_side,
    output logic signed [temp_width(FRAC_BITS)-1:0]  o_t2,
    output logic signed [temp_width(FRAC_BITS)-1:0]  o_diff,
    output t_side                                    o_side
);

    localparam int TW = temp_width(FRAC_BITS);

    logic signed [TW-1:0] lf_w;
    logic signed [TW-1:0] sf_w;
    logic signed [TW-1:0] ls_w;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;

    logic signed [TW-1:0] r_t2;
    logic signed [TW-1:0] r_diff;
    t_side                r_side;

    // Below half lightness T1 = l*F + l*s, otherwise l*F + s*F - l*s.
    always_comb begin
        lf_w = $signed(TW'(i_light) << FRAC_BITS);
        sf_w = $signed(TW'(i_sat) << FRAC_BITS);
        ls_w = $signed(TW'(i_lxs));
        t1   = lf_w + (i_low ? ls_w : (sf_w - ls_w));
        t2   = (lf_w <<< 1) - t1;
    end

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_t2   <= t2;
            r_diff <= t1 - t2;
            r_side <= i_side;
        end
    end

    assign o_t2   = r_t2;
    assign o_diff = r_diff;
    assign o_side = r_side;

endmodule

// ===== hdl/hsl_chan.sv =====
// Third and fourth pipeline stages for one color channel: blend and scale.
// Depends on hsl_pkg.

module hsl_chan import hsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  t_pipe_en                                 i_en,
    input  logic signed [temp_width(FRAC_BITS)-1:0]  i_t2,
    input  logic signed [temp_width(FRAC_BITS)-1:0]  i_diff,
    input  logic [W_BITS-1:0]                        i_weight,
    input  logic                                     i_gray,
    input  logic [CH_W-1:0]                          i_gray_val,
    output logic [CH_W-1:0]                          o_val
);

    localparam int TW = temp_width(FRAC_BITS);
    localparam int NW = TW + 8;
    localparam int PW = NW + 5;
    localparam int SH = 2 * FRAC_BITS + 2;

    logic signed [NW-1:0] t2_x;
    logic signed [NW-1:0] num;
    logic signed [PW-1:0] prod;
    logic [CH_W-1:0]      clamped;

    logic signed [NW-1:0] r_num;
    logic                 r_gray;
    logic [CH_W-1:0]      r_gray_val;
    logic [CH_W-1:0]      r_val;

    // Numerator in sixtieths: T2*60 + (T1 - T2)*weight.
    always_comb begin
        t2_x = NW'(i_t2);
        num  = (t2_x <<< 6) - (t2_x <<< 2)
             + NW'(i_diff) * NW'($signed({1'b0, i_weight}));
    end

    // 255/(60*F^2) equals 17/(4*F^2): multiply by 17, then shift.
    always_comb begin
        prod = (PW'(r_num) <<< 4) + PW'(r_num);
        if (prod[PW-1]) begin
            clamped = '0;
        end else if (|prod[PW-2:SH+CH_W]) begin
            clamped = CH_MAX;
        end else begin
            clamped = prod[SH+CH_W-1:SH];
        end
    end

    // Blend stage registers.
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_num      <= num;
            r_gray     <= i_gray;
            r_gray_val <= i_gray_val;
        end
    end

    // Output stage register.
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_val <= r_gray ? r_gray_val : clamped;
        end
    end

    assign o_val = r_val;

endmodule

// ===== hdl/hsl_to_rgb_converter.sv =====
// Top level of the HSL to RGB converter: stream ports and pipeline control.
// Depends on hsl_pkg, hsl_prep, hsl_temps and hsl_chan.

// The converter takes one HSL word per clock cycle while s_axis_tready is
// high. The edge that accepts a word loads it into the first of four
// register stages (hue wrap and l*s product, the two temporaries, the
// per-channel blend multiply, the final scale and saturation), and its RGB
// word is offered once it is loaded into the fourth. Each stage holds a
// valid bit. A stage loads whenever it is empty or the stage after it moves,
// so back pressure on the output stalls only the stages that are full and
// bubbles are squeezed out. With the output side always ready the sustained
// rate is one word per cycle. Zero saturation yields gray at lightness times
// 255, truncated and saturated to a byte.

module hsl_to_rgb_converter import hsl_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: hue_degrees[8:0], saturation[19:9], lightness[30:20].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int TW = temp_width(FRAC_BITS);

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    t_pipe_en pipe_en;

    logic [SL_W-1:0]      p_light;
    logic [SL_W-1:0]      p_sat;
    logic [2*SL_W-1:0]    p_lxs;
    logic                 p_low;
    t_side                p_side;
    logic signed [TW-1:0] t_t2;
    logic signed [TW-1:0] t_diff;
    t_side                t_side_q;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;

    // A stage may load when it is empty or its word moves on.
    always_comb begin
        rdy4       = !r_v4 || m_axis_tready;
        rdy3       = !r_v3 || rdy4;
        rdy2       = !r_v2 || rdy3;
        rdy1       = !r_v1 || rdy2;
        pipe_en.s1 = rdy1;
        pipe_en.s2 = rdy2;
        pipe_en.s3 = rdy3;
        pipe_en.s4 = rdy4;
    end

    // Valid bits follow the words down the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    hsl_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_hue   (s_axis_tdata[HUE_W-1:0]),
        .i_sat   (s_axis_tdata[HUE_W+SL_W-1:HUE_W]),
        .i_light (s_axis_tdata[HUE_W+2*SL_W-1:HUE_W+SL_W]),
        .o_light (p_light),
        .o_sat   (p_sat),
        .o_lxs   (p_lxs),
        .o_low   (p_low),
        .o_side  (p_side)
    );

    hsl_temps #(
        .FRAC_BITS (FRAC_BITS)
    ) u_temps (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_light (p_light),
        .i_sat   (p_sat),
        .i_lxs   (p_lxs),
        .i_low   (p_low),
        .i_side  (p_side),
        .o_t2    (t_t2),
        .o_diff  (t_diff),
        .o_side  (t_side_q)
    );

    hsl_chan #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chan_r (
        .i_clk      (i_clk),
        .i_en       (pipe_en),
        .i_t2       (t_t2),
        .i_diff     (t_diff),
        .i_weight   (t_side_q.w_r),
        .i_gray     (t_side_q.gray),
        .i_gray_val (t_side_q.gray_val),
        .o_val      (red)
    );

    hsl_chan #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chan_g (
        .i_clk      (i_clk),
        .i_en       (pipe_en),
        .i_t2       (t_t2),
        .i_diff     (t_diff),
        .i_weight   (t_side_q.w_g),
        .i_gray     (t_side_q.gray),
        .i_gray_val (t_side_q.gray_val),
        .o_val      (green)
    );

    hsl_chan #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chan_b (
        .i_clk      (i_clk),
        .i_en       (pipe_en),
        .i_t2       (t_t2),
        .i_diff     (t_diff),
        .i_weight   (t_side_q.w_b),
        .i_gray     (t_side_q.gray),
        .i_gray_val (t_side_q.gray_val),
        .o_val      (blue)
    );

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {blue, green, red};

endmodule

// ===== hdl/hsl_checker.sv =====
// Port-level checks for the HSL to RGB converter, bound to its top level.
// Depends on hsl_pkg and hsl_to_rgb_converter.

module hsl_checker import hsl_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled output word stays offered.
    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its data.
    a_out_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // When the sink takes words the whole pipeline moves, so input is taken.
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is ready");

    // Nothing comes out in the cycle after reset releases.
    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A word that appears on an idle output matches an earlier accepted input word.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid))
            |-> $past(s_axis_tvalid && s_axis_tready, 4))
        else $error("output appeared without matching input");

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
